[design/kcfe_pkg.sv]
// Package: key codes and lookup tables for the keyboard encoder.
`timescale 1ns / 1ps
package kcfe_pkg;

    // Mode keys
    localparam logic [7:0] KEY_KANA_OFF     = 8'hf0;
    localparam logic [7:0] KEY_KANA_OFF_ALT = 8'h1d;
    localparam logic [7:0] KEY_KANA_ON      = 8'hf1;
    localparam logic [7:0] KEY_KANA_ON_ALT  = 8'h15;
    localparam logic [7:0] KEY_CAPS         = 8'h14;

    // Fixed control-byte keys
    localparam logic [7:0] KEY_CTL_LF   = 8'hf2;
    localparam logic [7:0] KEY_CTL_CAN  = 8'hf3;
    localparam logic [7:0] KEY_CTL_ACK  = 8'hf4;
    localparam logic [7:0] KEY_CTL_FS   = 8'hf5;
    localparam logic [7:0] KEY_CTL_US   = 8'hf6;
    localparam logic [7:0] KEY_CTL_DEL  = 8'hf7;
    localparam logic [7:0] KEY_IGN_LO   = 8'hf8;
    localparam logic [7:0] KEY_IGN_HI   = 8'hfc;

    localparam logic [7:0] BYTE_LF  = 8'h0a;
    localparam logic [7:0] BYTE_CAN = 8'h18;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_FS  = 8'h1c;
    localparam logic [7:0] BYTE_US  = 8'h1f;
    localparam logic [7:0] BYTE_DEL = 8'h7f;

    // Ctrl-@ is the one ctrl key that pushes a zero byte
    localparam logic [7:0] KEY_AT      = 8'hc0;
    localparam logic [7:0] KEY_LTR_LO  = 8'h41;
    localparam logic [7:0] KEY_LTR_HI  = 8'h5a;
    localparam logic [7:0] CTRL_OFFSET = 8'h40;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] SEVEN_MASK  = 8'h7f;

    function automatic logic [7:0] ctrl_lookup(input logic [7:0] c);
        logic [7:0] r;
        if (c >= KEY_LTR_LO && c <= KEY_LTR_HI) begin
            r = c - CTRL_OFFSET;
        end else begin
            case (c)
                8'hdb:   r = 8'h1b;
                8'hdc:   r = 8'h1c;
                8'hdd:   r = 8'h1d;
                8'hde:   r = 8'h1e;
                8'he2:   r = 8'h1f;
                8'hbf:   r = 8'h7f;
                default: r = 8'h00;
            endcase
        end
        return r;
    endfunction

    function automatic logic [7:0] kana_lookup(input logic [7:0] c, input logic sh);
        logic [7:0] r;
        case (c)
            8'h31:   r = 8'hc7;
            8'h32:   r = 8'hcc;
            8'h33:   r = sh ? 8'ha7 : 8'hb1;
            8'h34:   r = sh ? 8'ha9 : 8'hb3;
            8'h35:   r = sh ? 8'haa : 8'hb4;
            8'h36:   r = sh ? 8'hab : 8'hb5;
            8'h37:   r = sh ? 8'hac : 8'hd4;
            8'h38:   r = sh ? 8'had : 8'hd5;
            8'h39:   r = sh ? 8'hae : 8'hd6;
            8'h30:   r = sh ? 8'ha6 : 8'hdc;
            8'hbd:   r = 8'hce;
            8'hde:   r = 8'hcd;
            8'hdc:   r = 8'hb0;
            8'h51:   r = 8'hc0;
            8'h57:   r = 8'hc3;
            8'h45:   r = 8'hb2;
            8'h52:   r = 8'hbd;
            8'h54:   r = 8'hb6;
            8'h59:   r = 8'hdd;
            8'h55:   r = 8'hc5;
            8'h49:   r = 8'hc6;
            8'h4f:   r = 8'hd7;
            8'h50:   r = 8'hbe;
            8'hc0:   r = 8'hde;
            8'hdb:   r = sh ? 8'ha2 : 8'hdf;
            8'h41:   r = 8'hc1;
            8'h53:   r = 8'hc4;
            8'h44:   r = 8'hbc;
            8'h46:   r = 8'hca;
            8'h47:   r = 8'hb7;
            8'h48:   r = 8'hb8;
            8'h4a:   r = 8'hcf;
            8'h4b:   r = 8'hc9;
            8'h4c:   r = 8'hd8;
            8'hbb:   r = 8'hda;
            8'hba:   r = 8'hb9;
            8'hdd:   r = sh ? 8'ha3 : 8'hd1;
            8'h5a:   r = sh ? 8'haf : 8'hc2;
            8'h58:   r = 8'hbb;
            8'h43:   r = 8'hbf;
            8'h56:   r = 8'hcb;
            8'h42:   r = 8'hba;
            8'h4e:   r = 8'hd0;
            8'h4d:   r = 8'hd3;
            8'hbc:   r = sh ? 8'ha4 : 8'hc8;
            8'hbe:   r = sh ? 8'ha1 : 8'hd9;
            8'hbf:   r = sh ? 8'ha5 : 8'hd2;
            8'he2:   r = 8'hdb;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ascii_lookup(input logic [7:0] c, input logic sh,
                                                input logic cp);
        logic [7:0] r;
        if (c >= KEY_LTR_LO && c <= KEY_LTR_HI) begin
            r = (cp ^ sh) ? c : c + CASE_OFFSET;
        end else begin
            case (c)
                8'h31:   r = sh ? 8'h21 : 8'h31;
                8'h32:   r = sh ? 8'h22 : 8'h32;
                8'h33:   r = sh ? 8'h23 : 8'h33;
                8'h34:   r = sh ? 8'h24 : 8'h34;
                8'h35:   r = sh ? 8'h25 : 8'h35;
                8'h36:   r = sh ? 8'h26 : 8'h36;
                8'h37:   r = sh ? 8'h27 : 8'h37;
                8'h38:   r = sh ? 8'h28 : 8'h38;
                8'h39:   r = sh ? 8'h29 : 8'h39;
                8'h30:   r = sh ? 8'h00 : 8'h30;
                8'h20:   r = 8'h20;
                8'h08:   r = 8'h08;
                8'h09:   r = 8'h09;
                8'h0d:   r = 8'h0d;
                8'h1b:   r = 8'h1b;
                8'h2e:   r = 8'h7f;
                8'hbd:   r = sh ? 8'h3d : 8'h2d;
                8'hde:   r = sh ? 8'h7e : 8'h5e;
                8'hdc:   r = sh ? 8'h7c : 8'h5c;
                8'hc0:   r = sh ? 8'h60 : 8'h40;
                8'hdb:   r = sh ? 8'h7b : 8'h5b;
                8'hdd:   r = sh ? 8'h7d : 8'h5d;
                8'hbb:   r = sh ? 8'h2b : 8'h3b;
                8'hba:   r = sh ? 8'h2a : 8'h3a;
                8'hbc:   r = sh ? 8'h3c : 8'h2c;
                8'hbe:   r = sh ? 8'h3e : 8'h2e;
                8'hbf:   r = sh ? 8'h3f : 8'h2f;
                8'he2:   r = sh ? 8'h5f : 8'h5c;
                default: r = 8'h00;
            endcase
        end
        return r;
    endfunction

endpackage

[design/kcfe_if.sv]
// Interfaces: input item channel and result item channel of the keyboard encoder.
`timescale 1ns / 1ps
interface kcfe_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] key_code;
    logic       key_repeat;
    logic       shift_held;
    logic       ctrl_held;

    modport source (output valid, func, key_code, key_repeat, shift_held, ctrl_held,
                    input ready);
    modport sink   (input valid, func, key_code, key_repeat, shift_held, ctrl_held,
                    output ready);
endinterface

interface kcfe_out_if #(parameter int OCC_W = 5);
    logic             valid;
    logic             ready;
    logic [7:0]       read_byte;
    logic             read_valid;
    logic [OCC_W-1:0] bytes_held;
    logic             kana_mode_now;
    logic             caps_now;
    logic             byte_dropped;

    modport source (output valid, read_byte, read_valid, bytes_held, kana_mode_now,
                    caps_now, byte_dropped, input ready);
    modport sink   (input valid, read_byte, read_valid, bytes_held, kana_mode_now,
                    caps_now, byte_dropped, output ready);
endinterface

[design/keycode_to_char_encoder_fifo_core.sv]
// Top level: key code to character encoder with a byte queue.
`timescale 1ns / 1ps
// Takes one item per clock unless stalled: a key press is decoded and its byte pushed
// into a circular queue of QUEUE_DEPTH bytes (the oldest byte is overwritten when full),
// a read pops the oldest byte. Each item yields one result in the next cycle; the
// decode, the single queue write port and the registered queue read all fit in that
// cycle, so the sustained rate is one item per cycle. The input is ready whenever the
// result register is empty or being taken in the same cycle. The result channel's OCC_W
// must be $clog2(QUEUE_DEPTH + 1). The kana width register resets to 8-bit kana output.
module keycode_to_char_encoder_fifo_core
    import kcfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    kcfe_in_if.sink           i_in,
    kcfe_out_if.source        o_out
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);
    localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);

    logic [7:0]       r_mem [QUEUE_DEPTH];
    logic             r_kana_eight_bit;
    logic             r_kana_mode, n_kana_mode;
    logic             r_caps, n_caps;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [OCC_W-1:0] r_occ, n_occ;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_read_valid;
    logic [OCC_W-1:0] r_out_occ;
    logic             r_out_kana;
    logic             r_out_caps;
    logic             r_out_dropped;

    logic       accept;
    logic       pop;
    logic       push;
    logic       dropped;
    logic [7:0] push_byte;
    logic       mode_key;
    logic [7:0] ctrl_byte;
    logic [7:0] kana_byte;
    logic [7:0] ascii_byte;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // Press decode, in priority order
    always_comb begin
        ctrl_byte  = ctrl_lookup(i_in.key_code);
        kana_byte  = kana_lookup(i_in.key_code, i_in.shift_held);
        ascii_byte = ascii_lookup(i_in.key_code, i_in.shift_held, r_caps);
        if (!r_kana_eight_bit) begin
            kana_byte = kana_byte & SEVEN_MASK;
        end
        mode_key = (i_in.key_code == KEY_KANA_OFF) || (i_in.key_code == KEY_KANA_OFF_ALT) ||
                   (i_in.key_code == KEY_KANA_ON)  || (i_in.key_code == KEY_KANA_ON_ALT)  ||
                   (i_in.key_code == KEY_CAPS);
        n_kana_mode = r_kana_mode;
        n_caps      = r_caps;
        push        = 1'b0;
        push_byte   = 8'h00;
        if (mode_key) begin
            // autorepeat of a mode key does nothing
            if (!i_in.key_repeat) begin
                if (i_in.key_code == KEY_KANA_OFF || i_in.key_code == KEY_KANA_OFF_ALT) begin
                    n_kana_mode = 1'b0;
                end else if (i_in.key_code == KEY_KANA_ON ||
                             i_in.key_code == KEY_KANA_ON_ALT) begin
                    n_kana_mode = 1'b1;
                end else begin
                    n_caps = !r_caps;
                end
            end
        end else if (i_in.key_code >= KEY_CTL_LF && i_in.key_code <= KEY_CTL_DEL) begin
            push = 1'b1;
            case (i_in.key_code)
                KEY_CTL_LF:  push_byte = BYTE_LF;
                KEY_CTL_CAN: push_byte = BYTE_CAN;
                KEY_CTL_ACK: push_byte = BYTE_ACK;
                KEY_CTL_FS:  push_byte = BYTE_FS;
                KEY_CTL_US:  push_byte = BYTE_US;
                default:     push_byte = BYTE_DEL;
            endcase
        end else if (i_in.key_code >= KEY_IGN_LO && i_in.key_code <= KEY_IGN_HI) begin
            push = 1'b0;
        end else if (i_in.ctrl_held && (ctrl_byte != 8'h00 || i_in.key_code == KEY_AT)) begin
            push      = 1'b1;
            push_byte = ctrl_byte;
        end else if (r_kana_mode && kana_byte != 8'h00) begin
            push      = 1'b1;
            push_byte = kana_byte;
        end else if (ascii_byte != 8'h00) begin
            push      = 1'b1;
            push_byte = ascii_byte;
        end
        // a read leaves the mode flags alone
        if (i_in.func) begin
            push        = 1'b0;
            n_kana_mode = r_kana_mode;
            n_caps      = r_caps;
        end
    end

    // Queue pointers and occupancy
    always_comb begin
        pop      = i_in.func && (r_occ != '0);
        dropped  = push && (r_occ == OCC_FULL);
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_occ    = r_occ;
        if (pop || dropped) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_occ = r_occ - OCC_ONE;
        end else if (push && !dropped) begin
            n_occ = r_occ + OCC_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kana_eight_bit <= 1'b1;
            r_kana_mode      <= 1'b0;
            r_caps           <= 1'b0;
            r_rd_ptr         <= '0;
            r_wr_ptr         <= '0;
            r_occ            <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_kana_eight_bit <= i_cfg_wdata;
            end
            if (accept) begin
                r_kana_mode <= n_kana_mode;
                r_caps      <= n_caps;
                r_rd_ptr    <= n_rd_ptr;
                r_wr_ptr    <= n_wr_ptr;
                r_occ       <= n_occ;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Queue memory and result payload
    always_ff @(posedge i_clk) begin
        if (accept && push) begin
            r_mem[r_wr_ptr] <= push_byte;
        end
        if (accept) begin
            r_out_byte       <= pop ? r_mem[r_rd_ptr] : 8'h00;
            r_out_read_valid <= pop;
            r_out_occ        <= n_occ;
            r_out_kana       <= n_kana_mode;
            r_out_caps       <= n_caps;
            r_out_dropped    <= dropped;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.read_byte     = r_out_byte;
    assign o_out.read_valid    = r_out_read_valid;
    assign o_out.bytes_held    = r_out_occ;
    assign o_out.kana_mode_now = r_out_kana;
    assign o_out.caps_now      = r_out_caps;
    assign o_out.byte_dropped  = r_out_dropped;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_FULL)
        else $error("queue occupancy above depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == '0) |-> (r_rd_ptr == r_wr_ptr))
        else $error("empty queue with unequal pointers");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dropped) |-> (r_out_occ == OCC_FULL))
        else $error("dropped byte while queue not full");

    a_pop_nodrop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_read_valid) |-> !r_out_dropped)
        else $error("read and drop in one item");

    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.func && r_occ == '0) |=> (r_occ == '0 && $stable(r_rd_ptr)))
        else $error("empty read changed queue state");

endmodule

[tb/tb_keycode_to_char_encoder_fifo_core.sv]
// Testbench: random and directed key items against a behavioral copy of the encoder and queue.
`timescale 1ns / 1ps
module tb_keycode_to_char_encoder_fifo_core
    import kcfe_pkg::*;
();

    localparam int QUEUE_DEPTH = 16;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic {
        FN_PRESS = 1'b0,
        FN_READ  = 1'b1
    } t_key_func;

    typedef struct packed {
        t_key_func  func;
        logic [7:0] key_code;
        logic       key_repeat;
        logic       shift_held;
        logic       ctrl_held;
    } t_key_item;

    typedef struct packed {
        logic [7:0]       read_byte;
        logic             read_valid;
        logic [OCC_W-1:0] bytes_held;
        logic             kana_mode_now;
        logic             caps_now;
        logic             byte_dropped;
    } t_enc_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    kcfe_in_if                       key_ch ();
    kcfe_out_if #(.OCC_W(OCC_W))     enc_ch ();

    keycode_to_char_encoder_fifo_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (key_ch),
        .o_out      (enc_ch)
    );

    always #10 i_clk = ~i_clk;

    t_key_item   key_items[$];
    t_enc_result encoder_results[$];
    int unsigned issued_cnt = 0;
    int unsigned taken_cnt  = 0;
    int unsigned fail_cnt   = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    logic        no_idle    = 1'b0;

    // Encoder state as seen from outside
    logic        kana_8bit = 1'b1;
    logic        kana_on   = 1'b0;
    logic        caps_on   = 1'b0;
    logic [7:0]  byte_store [QUEUE_DEPTH];
    int unsigned rd_slot   = 0;
    int unsigned wr_slot   = 0;
    int unsigned held_cnt  = 0;

    function automatic int unsigned next_slot(input int unsigned p);
        return (p == QUEUE_DEPTH - 1) ? 0 : p + 1;
    endfunction

    function automatic logic [7:0] ctrl_byte(input logic [7:0] c);
        if (c >= KEY_LTR_LO && c <= KEY_LTR_HI) return c - CTRL_OFFSET;
        if (c >= 8'hdb && c <= 8'hde) return c - 8'hc0;
        if (c == 8'he2) return BYTE_US;
        if (c == 8'hbf) return BYTE_DEL;
        return 8'h00;
    endfunction

    function automatic logic [7:0] kana_byte(input logic [7:0] c, input logic sh);
        logic [15:0] pair;  // {shifted, plain}
        case (c)
            8'h30: pair = 16'ha6dc;  8'h31: pair = 16'hc7c7;  8'h32: pair = 16'hcccc;
            8'h33: pair = 16'ha7b1;  8'h34: pair = 16'ha9b3;  8'h35: pair = 16'haab4;
            8'h36: pair = 16'habb5;  8'h37: pair = 16'hacd4;  8'h38: pair = 16'hadd5;
            8'h39: pair = 16'haed6;
            8'h41: pair = 16'hc1c1;  8'h42: pair = 16'hbaba;  8'h43: pair = 16'hbfbf;
            8'h44: pair = 16'hbcbc;  8'h45: pair = 16'hb2b2;  8'h46: pair = 16'hcaca;
            8'h47: pair = 16'hb7b7;  8'h48: pair = 16'hb8b8;  8'h49: pair = 16'hc6c6;
            8'h4a: pair = 16'hcfcf;  8'h4b: pair = 16'hc9c9;  8'h4c: pair = 16'hd8d8;
            8'h4d: pair = 16'hd3d3;  8'h4e: pair = 16'hd0d0;  8'h4f: pair = 16'hd7d7;
            8'h50: pair = 16'hbebe;  8'h51: pair = 16'hc0c0;  8'h52: pair = 16'hbdbd;
            8'h53: pair = 16'hc4c4;  8'h54: pair = 16'hb6b6;  8'h55: pair = 16'hc5c5;
            8'h56: pair = 16'hcbcb;  8'h57: pair = 16'hc3c3;  8'h58: pair = 16'hbbbb;
            8'h59: pair = 16'hdddd;  8'h5a: pair = 16'hafc2;
            8'hba: pair = 16'hb9b9;  8'hbb: pair = 16'hdada;  8'hbc: pair = 16'ha4c8;
            8'hbd: pair = 16'hcece;  8'hbe: pair = 16'ha1d9;  8'hbf: pair = 16'ha5d2;
            8'hc0: pair = 16'hdede;  8'hdb: pair = 16'ha2df;  8'hdc: pair = 16'hb0b0;
            8'hdd: pair = 16'ha3d1;  8'hde: pair = 16'hcdcd;  8'he2: pair = 16'hdbdb;
            default: pair = 16'h0000;
        endcase
        return sh ? pair[15:8] : pair[7:0];
    endfunction

    function automatic logic [7:0] ascii_byte(input logic [7:0] c, input logic sh,
                                              input logic cp);
        logic [15:0] pair;  // {shifted, plain}
        if (c >= KEY_LTR_LO && c <= KEY_LTR_HI) return (cp ^ sh) ? c : c + CASE_OFFSET;
        // shifted digits land on ! through )
        if (c >= 8'h31 && c <= 8'h39) return sh ? c - 8'h10 : c;
        case (c)
            8'h30: pair = 16'h0030;  8'h20: pair = 16'h2020;  8'h08: pair = 16'h0808;
            8'h09: pair = 16'h0909;  8'h0d: pair = 16'h0d0d;  8'h1b: pair = 16'h1b1b;
            8'h2e: pair = 16'h7f7f;  8'hbd: pair = 16'h3d2d;  8'hde: pair = 16'h7e5e;
            8'hdc: pair = 16'h7c5c;  8'hc0: pair = 16'h6040;  8'hdb: pair = 16'h7b5b;
            8'hdd: pair = 16'h7d5d;  8'hbb: pair = 16'h2b3b;  8'hba: pair = 16'h2a3a;
            8'hbc: pair = 16'h3c2c;  8'hbe: pair = 16'h3e2e;  8'hbf: pair = 16'h3f2f;
            8'he2: pair = 16'h5f5c;
            default: pair = 16'h0000;
        endcase
        return sh ? pair[15:8] : pair[7:0];
    endfunction

    task automatic encode_key_item(input t_key_item it, output t_enc_result res);
        logic [7:0] ch;
        logic       push;
        res  = '0;
        ch   = 8'h00;
        push = 1'b0;
        if (it.func == FN_READ) begin
            if (held_cnt != 0) begin
                res.read_byte  = byte_store[rd_slot];
                res.read_valid = 1'b1;
                rd_slot        = next_slot(rd_slot);
                held_cnt       = held_cnt - 1;
            end
        end else if (it.key_code == KEY_KANA_OFF || it.key_code == KEY_KANA_OFF_ALT ||
                     it.key_code == KEY_KANA_ON || it.key_code == KEY_KANA_ON_ALT ||
                     it.key_code == KEY_CAPS) begin
            // autorepeat of a mode key does nothing
            if (!it.key_repeat) begin
                if (it.key_code == KEY_KANA_OFF || it.key_code == KEY_KANA_OFF_ALT) begin
                    kana_on = 1'b0;
                end else if (it.key_code == KEY_CAPS) begin
                    caps_on = ~caps_on;
                end else begin
                    kana_on = 1'b1;
                end
            end
        end else if (it.key_code >= KEY_CTL_LF && it.key_code <= KEY_CTL_DEL) begin
            push = 1'b1;
            case (it.key_code)
                KEY_CTL_LF:  ch = BYTE_LF;
                KEY_CTL_CAN: ch = BYTE_CAN;
                KEY_CTL_ACK: ch = BYTE_ACK;
                KEY_CTL_FS:  ch = BYTE_FS;
                KEY_CTL_US:  ch = BYTE_US;
                default:     ch = BYTE_DEL;
            endcase
        end else if (it.key_code < KEY_IGN_LO || it.key_code > KEY_IGN_HI) begin
            if (it.ctrl_held) begin
                ch   = ctrl_byte(it.key_code);
                push = (ch != 8'h00) || (it.key_code == KEY_AT);
            end
            if (!push && kana_on) begin
                ch = kana_byte(it.key_code, it.shift_held);
                if (!kana_8bit) ch = ch & SEVEN_MASK;
                push = (ch != 8'h00);
            end
            if (!push) begin
                ch   = ascii_byte(it.key_code, it.shift_held, caps_on);
                push = (ch != 8'h00);
            end
        end
        if (push) begin
            // full queue: drop the oldest byte
            if (held_cnt == QUEUE_DEPTH) begin
                rd_slot          = next_slot(rd_slot);
                held_cnt         = held_cnt - 1;
                res.byte_dropped = 1'b1;
            end
            byte_store[wr_slot] = ch;
            wr_slot             = next_slot(wr_slot);
            held_cnt            = held_cnt + 1;
        end
        res.bytes_held    = OCC_W'(held_cnt);
        res.kana_mode_now = kana_on;
        res.caps_now      = caps_on;
    endtask

    task automatic flag_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        fail_cnt++;
    endtask

    // Check the result item first, then predict the key item taken at this edge
    always @(posedge i_clk) begin : monitor
        t_enc_result want;
        t_enc_result got;
        t_enc_result next_res;
        if (i_rst_n && enc_ch.valid && enc_ch.ready) begin
            got.read_byte     = enc_ch.read_byte;
            got.read_valid    = enc_ch.read_valid;
            got.bytes_held    = enc_ch.bytes_held;
            got.kana_mode_now = enc_ch.kana_mode_now;
            got.caps_now      = enc_ch.caps_now;
            got.byte_dropped  = enc_ch.byte_dropped;
            if (encoder_results.size() == 0) begin
                $display("%0t: unexpected result item, expected none, actual %h", $time, got);
                fail_cnt++;
            end else begin
                want = encoder_results.pop_front();
                if (got.read_byte !== want.read_byte)
                    flag_mismatch("read_byte", want.read_byte, got.read_byte);
                if (got.read_valid !== want.read_valid)
                    flag_mismatch("read_valid", want.read_valid, got.read_valid);
                if (got.bytes_held !== want.bytes_held)
                    flag_mismatch("bytes_held", want.bytes_held, got.bytes_held);
                if (got.kana_mode_now !== want.kana_mode_now)
                    flag_mismatch("kana_mode_now", want.kana_mode_now, got.kana_mode_now);
                if (got.caps_now !== want.caps_now)
                    flag_mismatch("caps_now", want.caps_now, got.caps_now);
                if (got.byte_dropped !== want.byte_dropped)
                    flag_mismatch("byte_dropped", want.byte_dropped, got.byte_dropped);
            end
        end
        if (i_rst_n && key_ch.valid && key_ch.ready) begin
            encode_key_item(t_key_item'{t_key_func'(key_ch.func), key_ch.key_code,
                                        key_ch.key_repeat, key_ch.shift_held,
                                        key_ch.ctrl_held}, next_res);
            encoder_results.push_back(next_res);
            taken_cnt++;
        end
    end

    function automatic int unsigned pick_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Key item driver: hold an item until taken, then idle for a random gap
    always @(negedge i_clk) begin : driver
        t_key_item it;
        if (!i_rst_n) begin
            key_ch.valid <= 1'b0;
        end else if (key_ch.valid && taken_cnt != issued_cnt) begin
            // hold
        end else if (gap_left != 0 || key_items.size() == 0) begin
            if (gap_left != 0) gap_left--;
            key_ch.valid      <= 1'b0;
            key_ch.func       <= 1'($urandom_range(0, 1));
            key_ch.key_code   <= 8'($urandom_range(0, 255));
            key_ch.key_repeat <= 1'($urandom_range(0, 1));
            key_ch.shift_held <= 1'($urandom_range(0, 1));
            key_ch.ctrl_held  <= 1'($urandom_range(0, 1));
        end else begin
            it = key_items.pop_front();
            key_ch.valid      <= 1'b1;
            key_ch.func       <= it.func;
            key_ch.key_code   <= it.key_code;
            key_ch.key_repeat <= it.key_repeat;
            key_ch.shift_held <= it.shift_held;
            key_ch.ctrl_held  <= it.ctrl_held;
            issued_cnt++;
            gap_left = pick_pause();
        end
    end

    // Result receiver: random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            enc_ch.ready <= 1'b0;
        end else if (no_idle) begin
            enc_ch.ready <= 1'b1;
        end else if (stall_left != 0) begin
            enc_ch.ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 3) == 0) begin
            enc_ch.ready <= 1'b0;
            stall_left = pick_pause();
        end else begin
            enc_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [7:0] pick_key_code();
        logic [7:0] code;
        case ($urandom_range(0, 9))
            0, 1, 2: code = 8'(KEY_LTR_LO + $urandom_range(0, 25));
            3:       code = 8'(8'h30 + $urandom_range(0, 9));
            4, 5: begin
                case ($urandom_range(0, 17))
                    0:  code = 8'hbd;  1:  code = 8'hde;  2:  code = 8'hdc;
                    3:  code = KEY_AT; 4:  code = 8'hdb;  5:  code = 8'hdd;
                    6:  code = 8'hbb;  7:  code = 8'hba;  8:  code = 8'hbc;
                    9:  code = 8'hbe;  10: code = 8'hbf;  11: code = 8'he2;
                    12: code = 8'h20;  13: code = 8'h08;  14: code = 8'h09;
                    15: code = 8'h0d;  16: code = 8'h1b;
                    default: code = 8'h2e;
                endcase
            end
            6: begin
                case ($urandom_range(0, 4))
                    0:       code = KEY_KANA_OFF;
                    1:       code = KEY_KANA_OFF_ALT;
                    2:       code = KEY_KANA_ON;
                    3:       code = KEY_KANA_ON_ALT;
                    default: code = KEY_CAPS;
                endcase
            end
            7:       code = 8'(KEY_KANA_OFF + $urandom_range(0, 12));
            default: code = 8'($urandom_range(0, 255));
        endcase
        return code;
    endfunction

    task automatic push_key(input t_key_func f, input logic [7:0] code, input logic rep,
                            input logic sh, input logic ct);
        key_items.push_back('{f, code, rep, sh, ct});
    endtask

    task automatic wait_idle();
        while (key_items.size() != 0 || taken_cnt != issued_cnt ||
               encoder_results.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Write the kana width register while idle, then queue random key items
    task automatic run_phase(input logic kana_width, input int n, input int unsigned read_pct,
                             input logic burst);
        t_key_item it;
        wait_idle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = kana_width;
        kana_8bit   = kana_width;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'($urandom_range(0, 1));
        @(posedge i_clk);
        no_idle = burst;
        for (int i = 0; i < n; i++) begin
            it.func       = ($urandom_range(0, 99) < read_pct) ? FN_READ : FN_PRESS;
            it.key_code   = pick_key_code();
            it.key_repeat = ($urandom_range(0, 3) == 0);
            it.shift_held = 1'($urandom_range(0, 1));
            it.ctrl_held  = ($urandom_range(0, 3) == 0);
            key_items.push_back(it);
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = 1'b0;
        key_ch.valid      = 1'b0;
        key_ch.func       = FN_PRESS;
        key_ch.key_code   = 8'h00;
        key_ch.key_repeat = 1'b0;
        key_ch.shift_held = 1'b0;
        key_ch.ctrl_held  = 1'b0;
        enc_ch.ready      = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // Directed: empty read, case and caps, ctrl keys, fixed bytes, kana modes
        push_key(FN_READ,  8'h00,            1'b0, 1'b0, 1'b0);
        push_key(FN_PRESS, KEY_LTR_LO,       1'b0, 1'b0, 1'b0);
        push_key(FN_PRESS, KEY_LTR_LO,       1'b0, 1'b1, 1'b0);
        push_key(FN_PRESS, KEY_CAPS,         1'b0, 1'b0, 1'b0);
        push_key(FN_PRESS, KEY_CAPS,         1'b1, 1'b0, 1'b0);
        push_key(FN_PRESS, KEY_LTR_HI,       1'b0, 1'b0, 1'b0);
        push_key(FN_PRESS, KEY_LTR_HI,       1'b0, 1'b1, 1'b0);
        push_key(FN_PRESS, 8'h30,            1'b0, 1'b1, 1'b0);
        push_key(FN_PRESS, KEY_AT,           1'b0, 1'b0, 1'b1);
        push_key(FN_PRESS, 8'hdb,            1'b0, 1'b0, 1'b1);
        for (int c = KEY_CTL_LF; c <= KEY_CTL_DEL; c++)
            push_key(FN_PRESS, 8'(c),        1'b1, 1'b1, 1'b1);
        push_key(FN_PRESS, KEY_IGN_LO,       1'b0, 1'b0, 1'b0);
        push_key(FN_PRESS, KEY_IGN_HI,       1'b0, 1'b0, 1'b1);
        push_key(FN_PRESS, KEY_KANA_ON_ALT,  1'b0, 1'b0, 1'b0);
        push_key(FN_PRESS, 8'h33,            1'b0, 1'b1, 1'b0);
        push_key(FN_PRESS, KEY_KANA_OFF,     1'b1, 1'b0, 1'b0);
        push_key(FN_PRESS, 8'hff,            1'b1, 1'b1, 1'b1);
        push_key(FN_PRESS, KEY_KANA_OFF_ALT, 1'b0, 1'b0, 1'b0);
        push_key(FN_PRESS, KEY_KANA_ON,      1'b0, 1'b0, 1'b0);
        push_key(FN_PRESS, 8'h00,            1'b0, 1'b0, 1'b0);
        push_key(FN_READ,  8'hff,            1'b1, 1'b1, 1'b1);
        push_key(FN_READ,  8'h00,            1'b0, 1'b0, 1'b0);
        push_key(FN_READ,  8'h5a,            1'b0, 1'b1, 1'b0);

        run_phase(1'b0, 150, 40, 1'b0);
        run_phase(1'b1, 150, 20, 1'b1);
        run_phase(1'b0, 100, 65, 1'b0);
        run_phase(1'b1,  50, 40, 1'b0);

        wait_idle();
        repeat (4) @(negedge i_clk);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
